FILE: hw/rtl/hsv_background_mask_morphology_macros.svh
`ifndef HSV_BACKGROUND_MASK_MORPHOLOGY_MACROS_SVH
`define HSV_BACKGROUND_MASK_MORPHOLOGY_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define HBMM_ASSERT_SAME(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("hbmm: same-cycle check failed");

// Check that a condition implies an expression in the following cycle.
`define HBMM_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("hbmm: next-cycle check failed");

`endif

FILE: hw/rtl/hbmm_pkg.sv
package hbmm_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH     = 2048;
  localparam int DEF_DILATE_PASSES = 2;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int THR_W       = 8;
  localparam int SIZE_W      = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HUE_THRESHOLD        = 3'd0,
    REG_SATURATION_THRESHOLD = 3'd1,
    REG_VALUE_THRESHOLD      = 3'd2,
    REG_IMAGE_WIDTH          = 3'd3,
    REG_IMAGE_HEIGHT         = 3'd4
  } cfg_reg_t;

  localparam logic [THR_W-1:0]  RST_HUE_THRESHOLD        = 8'd20;
  localparam logic [THR_W-1:0]  RST_SATURATION_THRESHOLD = 8'd20;
  localparam logic [THR_W-1:0]  RST_VALUE_THRESHOLD      = 8'd40;
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH          = 12'd640;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT         = 12'd480;

  // Input beat kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Color conversion fixed point
  localparam int PIX_W         = 8;
  localparam int CH_W          = 9;
  localparam int FRAC_BITS     = 12;
  localparam int SAT_RECIP_NUM = 1044480;
  localparam int HUE_RECIP_NUM = 122880;
  localparam int SAT_RECIP_W   = 20;
  localparam int HUE_RECIP_W   = 17;
  localparam int HUE_SPAN      = 180;

  // Line store and window scan
  localparam int SLOT_BITS = 3;
  localparam int TAP_CNT_W = 4;
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT = 4'd9;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } tap_ofs_t;

  // Window offset of scan step k: 3x3 square or 5x5 cross
  function automatic tap_ofs_t tap_offset(input logic square, input logic [TAP_CNT_W-1:0] k);
    tap_ofs_t o;
    o.dr = 3'sd0;
    o.dc = 3'sd0;
    if (square) begin
      case (k)
        4'd0: begin o.dr = -3'sd1; o.dc = -3'sd1; end
        4'd1: begin o.dr = -3'sd1; o.dc =  3'sd0; end
        4'd2: begin o.dr = -3'sd1; o.dc =  3'sd1; end
        4'd3: begin o.dr =  3'sd0; o.dc = -3'sd1; end
        4'd4: begin o.dr =  3'sd0; o.dc =  3'sd0; end
        4'd5: begin o.dr =  3'sd0; o.dc =  3'sd1; end
        4'd6: begin o.dr =  3'sd1; o.dc = -3'sd1; end
        4'd7: begin o.dr =  3'sd1; o.dc =  3'sd0; end
        4'd8: begin o.dr =  3'sd1; o.dc =  3'sd1; end
        default: begin o.dr = 3'sd0; o.dc = 3'sd0; end
      endcase
    end else begin
      case (k)
        4'd0: begin o.dr = -3'sd2; o.dc =  3'sd0; end
        4'd1: begin o.dr = -3'sd1; o.dc =  3'sd0; end
        4'd2: begin o.dr =  3'sd0; o.dc =  3'sd0; end
        4'd3: begin o.dr =  3'sd1; o.dc =  3'sd0; end
        4'd4: begin o.dr =  3'sd2; o.dc =  3'sd0; end
        4'd5: begin o.dr =  3'sd0; o.dc = -3'sd2; end
        4'd6: begin o.dr =  3'sd0; o.dc = -3'sd1; end
        4'd7: begin o.dr =  3'sd0; o.dc =  3'sd1; end
        4'd8: begin o.dr =  3'sd0; o.dc =  3'sd2; end
        default: begin o.dr = 3'sd0; o.dc = 3'sd0; end
      endcase
    end
    return o;
  endfunction

  // Controller
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV_A,
    ST_CONV_B,
    ST_CONV_C,
    ST_CONV_D,
    ST_PUSH,
    ST_CHECK,
    ST_EVAL,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load_input;
    logic push_pixel;
    logic stage_next;
    logic eval_start;
    logic eval_step;
    logic advance;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pixel_take;
    logic stage_ready;
    logic stage_last;
    logic eval_done;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/hbmm_ram.sv
module hbmm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/hbmm_hsv.sv
module hbmm_hsv (
  input  logic                        clk,
  input  logic [hbmm_pkg::PIX_W-1:0]  blue,
  input  logic [hbmm_pkg::PIX_W-1:0]  green,
  input  logic [hbmm_pkg::PIX_W-1:0]  red,
  output logic [hbmm_pkg::CH_W-1:0]   hue,
  output logic [hbmm_pkg::CH_W-1:0]   sat,
  output logic [hbmm_pkg::PIX_W-1:0]  val
);

  localparam int PW     = hbmm_pkg::PIX_W;
  localparam int CW     = hbmm_pkg::CH_W;
  localparam int SRW    = hbmm_pkg::SAT_RECIP_W;
  localparam int HRW    = hbmm_pkg::HUE_RECIP_W;
  localparam int FB     = hbmm_pkg::FRAC_BITS;
  localparam int LEVELS = 1 << PW;
  localparam int NUM_W  = PW + 4;
  localparam int SP_W   = PW + SRW;
  localparam int HP_W   = NUM_W + HRW + 1;

  // Rounded reciprocal tables, built at elaboration
  logic [SRW-1:0] sat_recip [LEVELS];
  logic [HRW-1:0] hue_recip [LEVELS];

  for (genvar i = 0; i < LEVELS; i++) begin : g_recip
    localparam int Den  = (i == 0) ? 1 : 2 * i;
    localparam int SatR = (i == 0) ? 0 : (2 * hbmm_pkg::SAT_RECIP_NUM + i) / Den;
    localparam int HueR = (i == 0) ? 0 : (2 * hbmm_pkg::HUE_RECIP_NUM + i) / Den;
    assign sat_recip[i] = SRW'(SatR);
    assign hue_recip[i] = HRW'(HueR);
  end

  // Step one: max, min, spread, hue numerator and reciprocals
  logic [PW-1:0]           mx;
  logic [PW-1:0]           mn;
  logic [PW-1:0]           spread;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] bs, gs, rs, ds;

  always_comb begin
    mx = blue;
    if (green > mx) mx = green;
    if (red > mx) mx = red;
    mn = blue;
    if (green < mn) mn = green;
    if (red < mn) mn = red;
    spread = mx - mn;
    bs = $signed({4'b0000, blue});
    gs = $signed({4'b0000, green});
    rs = $signed({4'b0000, red});
    ds = $signed({4'b0000, spread});
    if (mx == red) begin
      num = gs - bs;
    end else if (mx == green) begin
      num = bs - rs + (ds <<< 1);
    end else begin
      num = rs - gs + (ds <<< 2);
    end
  end

  logic [PW-1:0]           v1;
  logic [PW-1:0]           d1;
  logic signed [NUM_W-1:0] n1;
  logic [SRW-1:0]          sr1;
  logic [HRW-1:0]          hr1;

  always_ff @(posedge clk) begin
    v1  <= mx;
    d1  <= spread;
    n1  <= num;
    sr1 <= sat_recip[mx];
    hr1 <= hue_recip[spread];
  end

  // Step two: scale by the reciprocals
  logic [SP_W-1:0]        sp2;
  logic signed [HP_W-1:0] hp2;
  logic [PW-1:0]          v2;
  logic                   vnz2;
  logic                   dnz2;

  always_ff @(posedge clk) begin
    sp2  <= SP_W'(d1) * SP_W'(sr1);
    hp2  <= HP_W'(n1) * $signed({1'b0, hr1});
    v2   <= v1;
    vnz2 <= (v1 != '0);
    dnz2 <= (d1 != '0);
  end

  // Step three: round, floor and wrap the hue
  logic [SP_W:0]          sp_round;
  logic signed [HP_W-1:0] hp_round;
  logic signed [HP_W-1:0] h_floor;

  always_comb begin
    sp_round = (SP_W + 1)'(sp2) + (SP_W + 1)'(1 << (FB - 1));
    hp_round = hp2 + HP_W'(1 << (FB - 1));
    h_floor  = hp_round >>> FB;
  end

  always_ff @(posedge clk) begin
    val <= v2;
    sat <= vnz2 ? CW'(sp_round >> FB) : '0;
    if (!dnz2) begin
      hue <= '0;
    end else if (h_floor < 0) begin
      hue <= CW'(h_floor + HP_W'(hbmm_pkg::HUE_SPAN));
    end else begin
      hue <= CW'(h_floor);
    end
  end

endmodule

FILE: hw/rtl/hbmm_datapath.sv
module hbmm_datapath #(
  parameter int MAX_WIDTH     = hbmm_pkg::DEF_MAX_WIDTH,
  parameter int DILATE_PASSES = hbmm_pkg::DEF_DILATE_PASSES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hbmm_pkg::cmd_t                     cmd,
  output hbmm_pkg::status_t                  status,
  input  logic                               write_enable,
  input  logic [hbmm_pkg::CFG_INDEX_W-1:0]   write_index,
  input  logic [hbmm_pkg::CFG_DATA_W-1:0]    write_data,
  input  logic                               op,
  input  logic [hbmm_pkg::PIX_W-1:0]         fg_blue,
  input  logic [hbmm_pkg::PIX_W-1:0]         fg_green,
  input  logic [hbmm_pkg::PIX_W-1:0]         fg_red,
  input  logic [hbmm_pkg::PIX_W-1:0]         bg_blue,
  input  logic [hbmm_pkg::PIX_W-1:0]         bg_green,
  input  logic [hbmm_pkg::PIX_W-1:0]         bg_red,
  input  logic                               mask_stall,
  output logic                               mask_valid,
  output logic                               mask_bit,
  output logic                               last_in_frame
);

  localparam int STAGES = DILATE_PASSES + 2;
  localparam int SW     = $clog2(STAGES);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = hbmm_pkg::SIZE_W;
  localparam int NW     = WW + HW;
  localparam int SB     = hbmm_pkg::SLOT_BITS;
  localparam int AW     = SW + SB + CW;
  localparam int DEPTH  = STAGES * (1 << (SB + CW));
  localparam int PW     = hbmm_pkg::PIX_W;
  localparam int CHW    = hbmm_pkg::CH_W;
  localparam int TW     = hbmm_pkg::THR_W;
  localparam int KW     = hbmm_pkg::TAP_CNT_W;

  // Configuration registers
  logic [TW-1:0] hue_thr;
  logic [TW-1:0] sat_thr;
  logic [TW-1:0] val_thr;
  logic [HW-1:0] img_w;
  logic [HW-1:0] img_h;
  logic          cfg_clear;

  assign cfg_clear = write_enable &&
                     (write_index == hbmm_pkg::REG_IMAGE_WIDTH ||
                      write_index == hbmm_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_thr <= hbmm_pkg::RST_HUE_THRESHOLD;
      sat_thr <= hbmm_pkg::RST_SATURATION_THRESHOLD;
      val_thr <= hbmm_pkg::RST_VALUE_THRESHOLD;
      img_w   <= hbmm_pkg::RST_IMAGE_WIDTH;
      img_h   <= hbmm_pkg::RST_IMAGE_HEIGHT;
    end else if (write_enable) begin
      case (write_index)
        hbmm_pkg::REG_HUE_THRESHOLD:        hue_thr <= write_data[TW-1:0];
        hbmm_pkg::REG_SATURATION_THRESHOLD: sat_thr <= write_data[TW-1:0];
        hbmm_pkg::REG_VALUE_THRESHOLD:      val_thr <= write_data[TW-1:0];
        hbmm_pkg::REG_IMAGE_WIDTH:          img_w   <= write_data[HW-1:0];
        hbmm_pkg::REG_IMAGE_HEIGHT:         img_h   <= write_data[HW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size and register the derived sizes
  logic [WW-1:0] w_c;
  logic [HW-1:0] h_c;
  logic [WW-1:0] frame_w;
  logic [HW-1:0] frame_h;
  logic [NW-1:0] frame_n;
  logic [NW-1:0] reach1;
  logic [NW-1:0] reach2;

  always_comb begin
    if (img_w == '0) begin
      w_c = WW'(1);
    end else if (NW'(img_w) > NW'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(img_w);
    end
    h_c = (img_h == '0) ? HW'(1) : img_h;
  end

  always_ff @(posedge clk) begin
    frame_w <= w_c;
    frame_h <= h_c;
    frame_n <= NW'(frame_w) * NW'(frame_h);
    reach1  <= NW'(frame_w) + NW'(1);
    reach2  <= (NW'(frame_w) + NW'(1)) << 1;
  end

  // Capture the input beat
  logic          op_q;
  logic [PW-1:0] fb_q, fgr_q, fr_q, bb_q, bgr_q, br_q;

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      op_q  <= op;
      fb_q  <= fg_blue;
      fgr_q <= fg_green;
      fr_q  <= fg_red;
      bb_q  <= bg_blue;
      bgr_q <= bg_green;
      br_q  <= bg_red;
    end
  end

  // Color conversion, three register steps each
  logic [CHW-1:0] fg_h, fg_s, bg_h, bg_s;
  logic [PW-1:0]  fg_v, bg_v;

  hbmm_hsv u_fg_hsv (
    .clk   (clk),
    .blue  (fb_q),
    .green (fgr_q),
    .red   (fr_q),
    .hue   (fg_h),
    .sat   (fg_s),
    .val   (fg_v)
  );

  hbmm_hsv u_bg_hsv (
    .clk   (clk),
    .blue  (bb_q),
    .green (bgr_q),
    .red   (br_q),
    .hue   (bg_h),
    .sat   (bg_s),
    .val   (bg_v)
  );

  // Threshold the channel differences
  logic [CHW-1:0] dh, ds;
  logic [PW-1:0]  dv;
  logic           mask_q;

  always_comb begin
    dh = (fg_h > bg_h) ? fg_h - bg_h : bg_h - fg_h;
    ds = (fg_s > bg_s) ? fg_s - bg_s : bg_s - fg_s;
    dv = (fg_v > bg_v) ? fg_v - bg_v : bg_v - fg_v;
  end

  always_ff @(posedge clk) begin
    mask_q <= (dh > CHW'(hue_thr) && ds > CHW'(sat_thr)) || (dv > val_thr);
  end

  // Current filter stage
  logic [SW-1:0] cur;
  logic          stage_last;
  logic          square;

  assign stage_last = (cur == SW'(STAGES - 1));
  assign square     = (cur == '0) || stage_last;

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      cur <= '0;
    end else if (cmd.stage_next || cmd.advance) begin
      cur <= cur + SW'(1);
    end
  end

  // Per-stage position counters
  logic [CW-1:0] in_col    [STAGES];
  logic [HW-1:0] in_row    [STAGES];
  logic [NW-1:0] in_count  [STAGES];
  logic [CW-1:0] out_col   [STAGES];
  logic [HW-1:0] out_row   [STAGES];
  logic [NW-1:0] out_count [STAGES];

  logic          push_en;
  logic [SW-1:0] push_idx;
  logic          push_bit;
  logic          push_wrap;
  logic          out_en;
  logic          out_wrap;
  logic          frame_end;
  logic          acc;

  assign push_en   = cmd.push_pixel || cmd.advance;
  assign push_idx  = cmd.push_pixel ? '0 : cur + SW'(1);
  assign push_bit  = cmd.push_pixel ? mask_q : acc;
  assign push_wrap = (WW'(in_col[push_idx]) + WW'(1)) >= frame_w;
  assign out_en    = cmd.advance || cmd.emit;
  assign out_wrap  = (WW'(out_col[cur]) + WW'(1)) >= frame_w;
  assign frame_end = cmd.emit && ((out_count[cur] + NW'(1)) == frame_n);

  always_ff @(posedge clk) begin
    if (rst || cfg_clear || frame_end) begin
      for (int i = 0; i < STAGES; i++) begin
        in_col[i]    <= '0;
        in_row[i]    <= '0;
        in_count[i]  <= '0;
        out_col[i]   <= '0;
        out_row[i]   <= '0;
        out_count[i] <= '0;
      end
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (push_en && push_idx == SW'(i)) begin
          in_count[i] <= in_count[i] + NW'(1);
          if (push_wrap) begin
            in_col[i] <= '0;
            in_row[i] <= in_row[i] + HW'(1);
          end else begin
            in_col[i] <= in_col[i] + CW'(1);
          end
        end
        if (out_en && cur == SW'(i)) begin
          out_count[i] <= out_count[i] + NW'(1);
          if (out_wrap) begin
            out_col[i] <= '0;
            out_row[i] <= out_row[i] + HW'(1);
          end else begin
            out_col[i] <= out_col[i] + CW'(1);
          end
        end
      end
    end
  end

  // Stage may produce once its window rows are in
  logic [NW-1:0] reach;
  logic          stage_ready;

  assign reach       = square ? reach1 : reach2;
  assign stage_ready = (out_count[cur] < frame_n) &&
                       ((in_count[cur] == frame_n) ||
                        ((NW + 1)'(in_count[cur]) >
                         (NW + 1)'(out_count[cur]) + (NW + 1)'(reach)));

  // Window scan address
  hbmm_pkg::tap_ofs_t     ofs;
  logic [hbmm_pkg::TAP_CNT_W-1:0] tap_k;
  logic signed [HW+1:0]   tap_row;
  logic signed [WW+1:0]   tap_col;
  logic                   row_in;
  logic                   col_in;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic                   rdata;

  always_comb begin
    ofs     = hbmm_pkg::tap_offset(square, tap_k);
    tap_row = $signed({2'b00, out_row[cur]}) + (HW + 2)'(ofs.dr);
    tap_col = $signed({2'b00, WW'(out_col[cur])}) + (WW + 2)'(ofs.dc);
    row_in  = !tap_row[HW+1] && (tap_row[HW:0] < {1'b0, frame_h});
    col_in  = !tap_col[WW+1] && (tap_col[WW:0] < {1'b0, frame_w});
    raddr   = {cur, tap_row[SB-1:0], tap_col[CW-1:0]};
    waddr   = {push_idx, in_row[push_idx][SB-1:0], in_col[push_idx]};
  end

  hbmm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (push_en),
    .waddr (waddr),
    .wdata (push_bit),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fold taps: AND for erode (outside reads 1), OR for dilate (outside reads 0)
  logic tap_pend;
  logic tap_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_pend <= 1'b0;
      tap_k    <= '0;
    end else if (cmd.eval_start) begin
      tap_k    <= '0;
      tap_pend <= 1'b0;
      acc      <= square;
    end else if (cmd.eval_step) begin
      if (tap_k != hbmm_pkg::TAP_COUNT) begin
        tap_k <= tap_k + KW'(1);
      end
      tap_pend <= (tap_k != hbmm_pkg::TAP_COUNT);
      tap_live <= row_in && col_in;
      if (tap_pend) begin
        if (square) begin
          acc <= acc & (tap_live ? rdata : 1'b1);
        end else begin
          acc <= acc | (tap_live ? rdata : 1'b0);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= 1'b0;
    end else if (cmd.emit) begin
      mask_valid <= 1'b1;
    end else if (mask_valid && !mask_stall) begin
      mask_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mask_bit      <= acc;
      last_in_frame <= frame_end;
    end
  end

  assign status.pixel_take  = (op_q == hbmm_pkg::OP_PIXEL) && (in_count[0] < frame_n);
  assign status.stage_ready = stage_ready;
  assign status.stage_last  = stage_last;
  assign status.eval_done   = (tap_k == hbmm_pkg::TAP_COUNT);
  assign status.out_free    = !mask_valid || !mask_stall;

endmodule

FILE: hw/rtl/hbmm_ctrl.sv
module hbmm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  hbmm_pkg::status_t status,
  output hbmm_pkg::cmd_t    cmd
);

  hbmm_pkg::state_t state;
  hbmm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbmm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hbmm_pkg::ST_IDLE:   if (pixel_valid) state_next = hbmm_pkg::ST_CONV_A;
      hbmm_pkg::ST_CONV_A: state_next = hbmm_pkg::ST_CONV_B;
      hbmm_pkg::ST_CONV_B: state_next = hbmm_pkg::ST_CONV_C;
      hbmm_pkg::ST_CONV_C: state_next = hbmm_pkg::ST_CONV_D;
      hbmm_pkg::ST_CONV_D: state_next = hbmm_pkg::ST_PUSH;
      hbmm_pkg::ST_PUSH:   state_next = hbmm_pkg::ST_CHECK;
      hbmm_pkg::ST_CHECK: begin
        if (status.stage_ready) begin
          state_next = hbmm_pkg::ST_EVAL;
        end else if (status.stage_last) begin
          state_next = hbmm_pkg::ST_IDLE;
        end
      end
      hbmm_pkg::ST_EVAL:   if (status.eval_done) state_next = hbmm_pkg::ST_COMMIT;
      hbmm_pkg::ST_COMMIT: begin
        if (!status.stage_last) begin
          state_next = hbmm_pkg::ST_CHECK;
        end else if (status.out_free) begin
          state_next = hbmm_pkg::ST_IDLE;
        end
      end
      default: state_next = hbmm_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd         = '0;
    pixel_stall = rst || (state != hbmm_pkg::ST_IDLE);
    unique case (state)
      hbmm_pkg::ST_IDLE:   cmd.load_input = pixel_valid && !rst;
      hbmm_pkg::ST_PUSH:   cmd.push_pixel = status.pixel_take;
      hbmm_pkg::ST_CHECK: begin
        cmd.eval_start = status.stage_ready;
        cmd.stage_next = !status.stage_ready && !status.stage_last;
      end
      hbmm_pkg::ST_EVAL:   cmd.eval_step = 1'b1;
      hbmm_pkg::ST_COMMIT: begin
        cmd.advance = !status.stage_last;
        cmd.emit    = status.stage_last && status.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/hsv_background_mask_morphology.sv
// HSV background mask with morphological clean-up.
// Input channel: pixel_valid/pixel_stall carry one beat of op plus a foreground
// and a background BGR pixel in raster order; op flush drains pending rows.
// Output channel: mask_valid/mask_stall carry mask_bit and last_in_frame.
// Configuration: write_enable, write_index, write_data; write only when idle.
// Writing image_width or image_height restarts the frame.
// Each beat passes through color conversion (states CONV_A to CONV_D), one
// line-store write, and per filter stage one check plus, when the stage is
// ready, a nine-tap window scan through the read port of the shared line
// store. One beat is in flight at a time.
// Mask pixel k of a W-wide frame leaves on the beat that carries pixel
// k + 6*W + 6; after the last pixel each beat returns one more mask pixel.
// A stalled result sits in the output register; the next beat is still taken,
// and the block waits only when it must hand over a new result.
// Reset restores default registers and clears all frame counters; line store
// contents are not cleared and need no clearing.
`include "hsv_background_mask_morphology_macros.svh"

module hsv_background_mask_morphology #(
  parameter int MAX_WIDTH     = hbmm_pkg::DEF_MAX_WIDTH,
  parameter int DILATE_PASSES = hbmm_pkg::DEF_DILATE_PASSES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [hbmm_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [hbmm_pkg::CFG_DATA_W-1:0]  write_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic                             op,
  input  logic [hbmm_pkg::PIX_W-1:0]       fg_blue,
  input  logic [hbmm_pkg::PIX_W-1:0]       fg_green,
  input  logic [hbmm_pkg::PIX_W-1:0]       fg_red,
  input  logic [hbmm_pkg::PIX_W-1:0]       bg_blue,
  input  logic [hbmm_pkg::PIX_W-1:0]       bg_green,
  input  logic [hbmm_pkg::PIX_W-1:0]       bg_red,
  output logic                             mask_valid,
  input  logic                             mask_stall,
  output logic                             mask_bit,
  output logic                             last_in_frame
);

  hbmm_pkg::cmd_t    cmd;
  hbmm_pkg::status_t status;

  hbmm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  hbmm_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .DILATE_PASSES (DILATE_PASSES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .write_enable  (write_enable),
    .write_index   (write_index),
    .write_data    (write_data),
    .op            (op),
    .fg_blue       (fg_blue),
    .fg_green      (fg_green),
    .fg_red        (fg_red),
    .bg_blue       (bg_blue),
    .bg_green      (bg_green),
    .bg_red        (bg_red),
    .mask_stall    (mask_stall),
    .mask_valid    (mask_valid),
    .mask_bit      (mask_bit),
    .last_in_frame (last_in_frame)
  );

  // A result is only loaded when the output register can take it
  `HBMM_ASSERT_SAME(a_emit_room, clk, rst, cmd.emit, !mask_valid || !mask_stall)
  // At most one line-store write or result per cycle
  `HBMM_ASSERT_SAME(a_one_write, clk, rst, 1'b1, $onehot0({cmd.push_pixel, cmd.advance, cmd.emit}))
  // Busy right after taking a beat
  `HBMM_ASSERT_NEXT(a_busy_after_take, clk, rst, pixel_valid && !pixel_stall, pixel_stall)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int STAGE_CNT = 4;
  localparam int ROW_SLOTS = 8;
  localparam int LINE_LEN  = 2048;
  localparam logic [hbmm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic [1:0] {BEAT_PIXEL, BEAT_WRITE, BEAT_HOLD} beat_kind_t;

  typedef struct {
    beat_kind_t                           kind;
    logic                                 op;
    logic [7:0]                           fb, fgr, fr, bb, bgr, br;
    logic [hbmm_pkg::CFG_INDEX_W-1:0]     idx;
    logic [hbmm_pkg::CFG_DATA_W-1:0]      data;
  } beat_t;

  typedef struct {
    logic mask;
    logic last;
  } mask_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [hbmm_pkg::CFG_INDEX_W-1:0] write_index = '0;
  logic [hbmm_pkg::CFG_DATA_W-1:0] write_data = '0;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  logic op = hbmm_pkg::OP_PIXEL;
  logic [7:0] fg_blue = '0, fg_green = '0, fg_red = '0;
  logic [7:0] bg_blue = '0, bg_green = '0, bg_red = '0;
  logic mask_valid;
  logic mask_stall = 1'b0;
  logic mask_bit;
  logic last_in_frame;

  hsv_background_mask_morphology u_top (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .op(op),
    .fg_blue(fg_blue), .fg_green(fg_green), .fg_red(fg_red),
    .bg_blue(bg_blue), .bg_green(bg_green), .bg_red(bg_red),
    .mask_valid(mask_valid), .mask_stall(mask_stall),
    .mask_bit(mask_bit), .last_in_frame(last_in_frame)
  );

  always #1 clk = ~clk;

  // Mirror of the block's state
  bit line_mem [STAGE_CNT][ROW_SLOTS][LINE_LEN];
  int unsigned s_in_row[STAGE_CNT], s_in_col[STAGE_CNT], s_in_cnt[STAGE_CNT];
  int unsigned s_out_row[STAGE_CNT], s_out_col[STAGE_CNT], s_out_cnt[STAGE_CNT];
  int unsigned hue_thr = hbmm_pkg::RST_HUE_THRESHOLD;
  int unsigned sat_thr = hbmm_pkg::RST_SATURATION_THRESHOLD;
  int unsigned val_thr = hbmm_pkg::RST_VALUE_THRESHOLD;
  int unsigned img_w = hbmm_pkg::RST_IMAGE_WIDTH, img_h = hbmm_pkg::RST_IMAGE_HEIGHT;

  beat_t     stim_q[$];
  mask_res_t mask_q[$];
  int errors = 0;
  int n_pixels = 0, n_flush = 0, n_masks = 0, n_frames_done = 0;

  function automatic void clear_positions();
    for (int s = 0; s < STAGE_CNT; s++) begin
      s_in_row[s] = 0; s_in_col[s] = 0; s_in_cnt[s] = 0;
      s_out_row[s] = 0; s_out_col[s] = 0; s_out_cnt[s] = 0;
    end
  endfunction

  function automatic int unsigned eff_width();
    if (img_w == 0) return 1;
    if (img_w > LINE_LEN) return LINE_LEN;
    return img_w;
  endfunction

  // 8-bit HSV with fixed-point reciprocals, hue in half degrees
  function automatic void rgb_to_hsv(input int b, input int g, input int r,
                                     output int h, output int s, output int v);
    int mn, d, sdiv, hdiv, n, t;
    v = b; mn = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    d = v - mn;
    s = 0;
    if (v != 0) begin
      sdiv = (2 * hbmm_pkg::SAT_RECIP_NUM + v) / (2 * v);
      s = (d * sdiv + 2048) >> 12;
    end
    h = 0;
    if (d != 0) begin
      hdiv = (2 * hbmm_pkg::HUE_RECIP_NUM + d) / (2 * d);
      if (v == r) n = g - b;
      else if (v == g) n = b - r + 2 * d;
      else n = r - g + 4 * d;
      t = n * hdiv + 2048 + 64 * 4096;
      h = (t >> 12) - 64;
      if (h < 0) h += hbmm_pkg::HUE_SPAN;
    end
  endfunction

  function automatic bit stage_tap(int s, int r, int c, int w, int h, bit outside);
    if (r < 0 || r >= h || c < 0 || c >= w) return outside;
    return line_mem[s][r % ROW_SLOTS][c];
  endfunction

  function automatic void stage_store(int s, bit v, int unsigned w);
    line_mem[s][s_in_row[s] % ROW_SLOTS][s_in_col[s]] = v;
    s_in_cnt[s]++;
    s_in_col[s]++;
    if (s_in_col[s] >= w) begin
      s_in_col[s] = 0;
      s_in_row[s]++;
    end
  endfunction

  function automatic bit stage_filter(int s, int w, int h);
    int r, c;
    r = s_out_row[s];
    c = s_out_col[s];
    if (s == 0 || s == STAGE_CNT - 1) begin
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++)
          if (!stage_tap(s, r + dr, c + dc, w, h, 1'b1)) return 1'b0;
      return 1'b1;
    end
    for (int d = -2; d <= 2; d++)
      if (stage_tap(s, r + d, c, w, h, 1'b0) || stage_tap(s, r, c + d, w, h, 1'b0))
        return 1'b1;
    return 1'b0;
  endfunction

  // Work out the mask beat, if any, that an accepted input beat releases
  function automatic void predict_mask(beat_t it);
    int unsigned w, h, n, rad;
    int fh, fs, fv, bh, bs, bv, dh, ds, dv;
    bit m, ready, res;
    mask_res_t exp_res;
    w = eff_width();
    h = (img_h == 0) ? 1 : img_h;
    n = w * h;
    if (it.op == hbmm_pkg::OP_PIXEL && s_in_cnt[0] < n) begin
      rgb_to_hsv(it.fb, it.fgr, it.fr, fh, fs, fv);
      rgb_to_hsv(it.bb, it.bgr, it.br, bh, bs, bv);
      dh = (fh > bh) ? fh - bh : bh - fh;
      ds = (fs > bs) ? fs - bs : bs - fs;
      dv = (fv > bv) ? fv - bv : bv - fv;
      m = (dh > hue_thr && ds > sat_thr) || dv > val_thr;
      stage_store(0, m, w);
    end
    for (int s = 0; s < STAGE_CNT; s++) begin
      rad = (s == 0 || s == STAGE_CNT - 1) ? 1 : 2;
      if (s_out_cnt[s] >= n) ready = 1'b0;
      else if (s_in_cnt[s] == n) ready = 1'b1;
      else ready = s_in_cnt[s] > s_out_cnt[s] + rad * w + rad;
      if (!ready) continue;
      res = stage_filter(s, w, h);
      s_out_cnt[s]++;
      s_out_col[s]++;
      if (s_out_col[s] >= w) begin
        s_out_col[s] = 0;
        s_out_row[s]++;
      end
      if (s < STAGE_CNT - 1) begin
        stage_store(s + 1, res, w);
      end else begin
        exp_res.mask = res;
        exp_res.last = (s_out_cnt[s] == n);
        mask_q = {mask_q, exp_res};
        if (exp_res.last) clear_positions();
      end
    end
  endfunction

  function automatic void apply_write(logic [hbmm_pkg::CFG_INDEX_W-1:0] idx,
                                      logic [hbmm_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      hbmm_pkg::REG_HUE_THRESHOLD:        hue_thr = d[7:0];
      hbmm_pkg::REG_SATURATION_THRESHOLD: sat_thr = d[7:0];
      hbmm_pkg::REG_VALUE_THRESHOLD:      val_thr = d[7:0];
      hbmm_pkg::REG_IMAGE_WIDTH: begin
        img_w = d;
        clear_positions();
      end
      hbmm_pkg::REG_IMAGE_HEIGHT: begin
        img_h = d;
        clear_positions();
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(80, 15);
  endfunction

  // Queue builders
  function automatic void add_pixel(int fb, int fgr, int fr, int bb, int bgr, int br);
    beat_t it;
    it = '{kind: BEAT_PIXEL, op: hbmm_pkg::OP_PIXEL, fb: fb[7:0], fgr: fgr[7:0],
           fr: fr[7:0], bb: bb[7:0], bgr: bgr[7:0], br: br[7:0], idx: '0, data: '0};
    stim_q = {stim_q, it};
  endfunction

  function automatic void add_flush();
    beat_t it;
    it = '{kind: BEAT_PIXEL, op: hbmm_pkg::OP_FLUSH, fb: 8'($urandom), fgr: 8'($urandom),
           fr: 8'($urandom), bb: 8'($urandom), bgr: 8'($urandom), br: 8'($urandom),
           idx: '0, data: '0};
    stim_q = {stim_q, it};
  endfunction

  function automatic void add_write(logic [hbmm_pkg::CFG_INDEX_W-1:0] idx, int unsigned d);
    beat_t it;
    it = '{kind: BEAT_WRITE, op: hbmm_pkg::OP_PIXEL, fb: '0, fgr: '0, fr: '0,
           bb: '0, bgr: '0, br: '0, idx: idx, data: d[hbmm_pkg::CFG_DATA_W-1:0]};
    stim_q = {stim_q, it};
  endfunction

  function automatic void add_hold();
    beat_t it;
    it = '{kind: BEAT_HOLD, op: hbmm_pkg::OP_PIXEL, fb: '0, fgr: '0, fr: '0,
           bb: '0, bgr: '0, br: '0, idx: '0, data: '0};
    stim_q = {stim_q, it};
  endfunction

  function automatic int near_val(int base);
    int v;
    v = base + $signed($urandom_range(60)) - 30;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  // Random pixel pair: fully random, extremes, or a background close to the foreground
  function automatic void add_random_pixel();
    int fb, fgr, fr, r;
    r = $urandom_range(9);
    fb = $urandom_range(255); fgr = $urandom_range(255); fr = $urandom_range(255);
    if (r == 0) begin
      fb = $urandom_range(1) * 255; fgr = $urandom_range(1) * 255;
      fr = $urandom_range(1) * 255;
    end
    if (r < 4)
      add_pixel(fb, fgr, fr, $urandom_range(255), $urandom_range(255), $urandom_range(255));
    else
      add_pixel(fb, fgr, fr, near_val(fb), near_val(fgr), near_val(fr));
  endfunction

  function automatic int pick_thr();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(60);
  endfunction

  // Stimulus plan
  initial begin
    int w, h, eff_w, eff_h, cnt, stop_at, sent;
    // Directed: small frame, color corners and every hue branch
    add_write(hbmm_pkg::REG_IMAGE_WIDTH, 4);
    add_write(hbmm_pkg::REG_IMAGE_HEIGHT, 3);
    add_pixel(0, 0, 0, 255, 255, 255);
    add_pixel(255, 255, 255, 255, 255, 255);
    add_pixel(0, 0, 255, 0, 255, 0);
    add_pixel(255, 0, 0, 0, 0, 255);
    add_flush();
    add_pixel(10, 20, 200, 200, 20, 10);
    add_pixel(100, 100, 100, 0, 0, 0);
    add_pixel(200, 50, 120, 120, 50, 200);
    add_pixel(30, 240, 90, 90, 30, 240);
    add_pixel(1, 0, 0, 0, 0, 1);
    add_pixel(0, 128, 255, 255, 128, 0);
    add_pixel(77, 77, 77, 78, 77, 77);
    add_pixel(9, 9, 9, 9, 9, 9);
    add_pixel(5, 5, 5, 5, 5, 5);
    for (int i = 0; i < 30; i++) add_flush();
    // Threshold extremes and a single-pixel frame from zero sizes
    add_write(hbmm_pkg::REG_HUE_THRESHOLD, 0);
    add_write(hbmm_pkg::REG_SATURATION_THRESHOLD, 255);
    add_write(hbmm_pkg::REG_VALUE_THRESHOLD, 0);
    add_write(hbmm_pkg::REG_IMAGE_HEIGHT, 4095);
    add_write(hbmm_pkg::REG_IMAGE_WIDTH, 0);
    add_write(hbmm_pkg::REG_IMAGE_HEIGHT, 0);
    add_write(REG_UNUSED, 12'hfff);
    add_pixel(0, 0, 255, 255, 0, 0);
    add_pixel(0, 0, 255, 255, 0, 0);
    for (int i = 0; i < 10; i++) add_flush();
    add_write(hbmm_pkg::REG_HUE_THRESHOLD, 255);
    add_write(hbmm_pkg::REG_VALUE_THRESHOLD, 255);
    add_write(hbmm_pkg::REG_SATURATION_THRESHOLD, 0);

    // Random frames, each under its own setting; every input beat counts
    cnt = 60;
    stop_at = 2000;
    for (int f = 0; cnt < stop_at; f++) begin
      if (f == 3) begin
        w = 4095; h = 1;
      end else begin
        w = ($urandom_range(9) == 0) ? 0 : $urandom_range(12, 1);
        h = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
      end
      add_write(hbmm_pkg::REG_IMAGE_WIDTH, w);
      add_write(hbmm_pkg::REG_IMAGE_HEIGHT, h);
      add_write(hbmm_pkg::REG_HUE_THRESHOLD, pick_thr());
      add_write(hbmm_pkg::REG_SATURATION_THRESHOLD, pick_thr());
      add_write(hbmm_pkg::REG_VALUE_THRESHOLD, pick_thr() + 10);
      eff_w = (w == 0) ? 1 : (w > LINE_LEN ? LINE_LEN : w);
      eff_h = (h == 0) ? 1 : h;
      // Mostly whole frames, some cut short by the next size write;
      // the clamped wide row only gets its first stretch
      sent = 0;
      for (int i = 0; i < eff_w * eff_h; i++) begin
        if ($urandom_range(19) == 0 && eff_w < 100) break;
        if (i >= 150 || cnt >= stop_at) break;
        if ($urandom_range(24) == 0) begin
          add_flush();
          cnt++;
        end
        add_random_pixel();
        cnt++;
        sent++;
      end
      for (int i = 0; i < 6 * eff_w + 8; i++) begin
        if (i > sent + 2 || cnt >= stop_at) break;
        if ($urandom_range(9) == 0) add_random_pixel();
        else add_flush();
        cnt++;
      end
      if (f == 5) add_hold();
    end
  end

  // Drive input beats, register writes and hold-offs from the queue
  int gap_left = 0;
  int quiet = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    logic nxt_we;
    beat_t it;
    nxt_valid = pixel_valid;
    nxt_we = 1'b0;
    if (rst) begin
      nxt_valid = 1'b0;
      quiet = 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        it.op = op;
        it.fb = fg_blue; it.fgr = fg_green; it.fr = fg_red;
        it.bb = bg_blue; it.bgr = bg_green; it.br = bg_red;
        predict_mask(it);
        if (op == hbmm_pkg::OP_PIXEL) n_pixels++;
        else n_flush++;
        nxt_valid = 1'b0;
        quiet = 0;
      end else if (!pixel_valid && mask_q.size() == 0) begin
        quiet++;
      end else begin
        quiet = 0;
      end
      if (!nxt_valid && stim_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (stim_q[0].kind)
            BEAT_PIXEL: begin
              it = stim_q.pop_front();
              op <= it.op;
              fg_blue <= it.fb; fg_green <= it.fgr; fg_red <= it.fr;
              bg_blue <= it.bb; bg_green <= it.bgr; bg_red <= it.br;
              nxt_valid = 1'b1;
              gap_left = pick_gap();
            end
            BEAT_WRITE: begin
              // Write only once the block has gone quiet
              if (quiet >= 100) begin
                it = stim_q.pop_front();
                write_index <= it.idx;
                write_data <= it.data;
                nxt_we = 1'b1;
                apply_write(it.idx, it.data);
              end
            end
            default: begin
              if (mask_q.size() == 0) void'(stim_q.pop_front());
            end
          endcase
        end
      end
    end
    pixel_valid <= nxt_valid;
    write_enable <= nxt_we;
  end

  // Check mask beats and stall the output at random
  int stall_left = 0;
  always @(posedge clk) begin
    mask_res_t exp_res;
    if (!rst && mask_valid && !mask_stall) begin
      n_masks++;
      if (mask_q.size() == 0) begin
        $error("unexpected mask beat: mask_bit=%0b last_in_frame=%0b",
               mask_bit, last_in_frame);
        errors++;
      end else begin
        exp_res = mask_q.pop_front();
        if (mask_bit !== exp_res.mask) begin
          $error("mask_bit: expected %0b, got %0b", exp_res.mask, mask_bit);
          errors++;
        end
        if (last_in_frame !== exp_res.last) begin
          $error("last_in_frame: expected %0b, got %0b", exp_res.last, last_in_frame);
          errors++;
        end
        if (exp_res.last) n_frames_done++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      mask_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      mask_stall <= 1'b0;
    end
  end

  // Reset, then wait for the queues to drain
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (stim_q.size() == 0 && !pixel_valid && mask_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mask_q.size() != 0) begin
      $error("%0d mask beats never arrived", mask_q.size());
      errors++;
    end
    $display("Covered %0d pixel beats and %0d flush beats, %0d mask beats checked,",
             n_pixels, n_flush, n_masks);
    $display("%0d complete frames across many sizes and threshold settings.",
             n_frames_done);
    if (errors == 0) begin
      $display("** hsv_background_mask_morphology: PASSED **");
    end else begin
      $display("** hsv_background_mask_morphology: FAILED **");
    end
    $finish;
  end

  // Guard against a hang
  initial begin
    #8000000;
    $display("** hsv_background_mask_morphology: FAILED **");
    $finish;
  end

endmodule
